// ===== hw/rtl/nqse_pkg.sv =====
// Shared types and constants of the N-queens solution enumerator.
// Used by the register block, the attack check unit and the top level.
package nqse_pkg;

	// Default and upper bound of the board edge
	localparam int MAX_N_DEF = 8;

	// Width of a column or row counter (holds 0..8)
	localparam int COL_W = 4;

	// Width of one stored queen row
	localparam int ROW_W = 3;

	// Width of the board size register
	localparam int SIZE_W = 4;

	// Reset value of the board size register
	localparam logic [SIZE_W-1:0] BOARD_SIZE_RST = 4'd8;

	// Configuration port widths and register index
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_BOARD_SIZE = 1'b0;

	// Width of the result bitmap
	localparam int BITS_W = 64;

	// Candidate square handed to the attack check unit
	typedef struct packed {
		logic [COL_W-1:0] row;
		logic [COL_W-1:0] col;
	} cand_t;

endpackage

// ===== hw/rtl/n_queens_solution_enumerator_unit.sv =====
// N-queens solution enumerator, top level: request stream in, solution stream out.
// A request runs the search (candidate rows tried, backtrack steps), builds the bitmap and
// flushes it, after the resume state on a resume; an exhausted answer is flushed directly.
// One request in flight; the search sequencer with its attack check unit sets the rate.
// Reset clears the search state, the output valid and sets board_size to 8.
// Depends on nqse_pkg, nqse_apb_regs and nqse_attack_check.
module n_queens_solution_enumerator_unit
	import nqse_pkg::*;
#(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Request stream; s_tdata fields from bit 0: restart, zero fill
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	// Result stream; m_tdata fields from bit 0: board_bits
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BITS_W-1:0] m_tdata,
	// m_tuser fields from bit 0: found
	output logic              m_tuser,
	// Configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_RESUME = 5'b00010,
		ST_TRY    = 5'b00100,
		ST_BUILD  = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [ROW_W-1:0]   rows_q [MAX_N];
	logic [COL_W-1:0]   col_q;
	logic [COL_W-1:0]   row_q;
	logic [COL_W-1:0]   search_col_q;
	logic               started_q;
	logic               exhausted_q;
	logic               found_q;
	logic [BITS_W-1:0]  bits_q;
	logic               m_tvalid_q;
	logic [BITS_W-1:0]  m_tdata_q;
	logic               m_tuser_q;

	logic [SIZE_W-1:0]  board_size;
	logic [COL_W-1:0]   n;
	logic [COL_W-1:0]   resume_col;
	logic               s_fire;
	logic               out_free;
	logic               sq_free;
	cand_t              cand;
	logic [ROW_W-1:0]   cur_row;
	logic [6:0]         bit_pos;

	nqse_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.board_size (board_size)
	);

	// Saturate the board edge to MAX_N
	assign n = (board_size > COL_W'(MAX_N)) ? COL_W'(MAX_N) : board_size;

	// Resume column is min(search column, N)
	assign resume_col = (search_col_q > n) ? n : search_col_q;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;

	assign cand.row = row_q;
	assign cand.col = col_q;
	assign cur_row  = rows_q[col_q[IDX_W-1:0]];

	nqse_attack_check #(
		.MAX_N (MAX_N)
	) u_check (
		.cand (cand),
		.rows (rows_q),
		.free (sq_free)
	);

	// Bitmap position row*N+col of the column being built
	assign bit_pos = 7'(cur_row) * 7'(n) + 7'(col_q);

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			for (int c = 0; c < MAX_N; c++) begin
				rows_q[c] <= '0;
			end
			col_q        <= '0;
			row_q        <= '0;
			search_col_q <= '0;
			started_q    <= 1'b0;
			exhausted_q  <= 1'b0;
			found_q      <= 1'b0;
			bits_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (s_tdata[0] || !started_q) begin
							// Restart from an empty board
							for (int c = 0; c < MAX_N; c++) begin
								rows_q[c] <= '0;
							end
							col_q       <= '0;
							row_q       <= '0;
							exhausted_q <= 1'b0;
							started_q   <= 1'b1;
							state_q     <= ST_TRY;
						end else if (exhausted_q) begin
							search_col_q <= '0;
							found_q      <= 1'b0;
							bits_q       <= '0;
							state_q      <= ST_FLUSH;
						end else if (resume_col == '0) begin
							exhausted_q  <= 1'b1;
							search_col_q <= '0;
							found_q      <= 1'b0;
							bits_q       <= '0;
							state_q      <= ST_FLUSH;
						end else begin
							col_q   <= resume_col - 1'b1;
							state_q <= ST_RESUME;
						end
					end
				end
				ST_RESUME: begin
					// Continue after the stored row of this column
					row_q   <= {1'b0, cur_row} + 1'b1;
					state_q <= ST_TRY;
				end
				ST_TRY: begin
					if (col_q >= n) begin
						search_col_q <= n;
						col_q        <= '0;
						bits_q       <= '0;
						state_q      <= ST_BUILD;
					end else if (row_q < n) begin
						if (sq_free) begin
							rows_q[col_q[IDX_W-1:0]] <= row_q[ROW_W-1:0];
							col_q <= col_q + 1'b1;
							row_q <= '0;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else if (col_q == '0) begin
						exhausted_q  <= 1'b1;
						search_col_q <= '0;
						found_q      <= 1'b0;
						bits_q       <= '0;
						state_q      <= ST_FLUSH;
					end else begin
						// Backtrack one column
						col_q   <= col_q - 1'b1;
						state_q <= ST_RESUME;
					end
				end
				ST_BUILD: begin
					if (col_q < n) begin
						if ({1'b0, cur_row} < n) begin
							bits_q <= bits_q | (BITS_W'(1) << bit_pos[5:0]);
						end
						col_q <= col_q + 1'b1;
					end else begin
						found_q <= 1'b1;
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: load from the flush state, else drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FLUSH) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Output payload, no reset
	always_ff @(posedge clk) begin
		if ((state_q == ST_FLUSH) && out_free) begin
			m_tdata_q <= bits_q;
			m_tuser_q <= found_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== hw/rtl/nqse_apb_regs.sv =====
// APB-style configuration register block of the N-queens enumerator.
// Holds the board size register; depends on nqse_pkg.
module nqse_apb_regs
	import nqse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [SIZE_W-1:0] board_size
);

	logic [SIZE_W-1:0] board_size_q;
	logic              wr_en;
	logic              reg_index;

	assign pready    = 1'b1;
	assign reg_index = paddr[APB_AW-1];
	assign wr_en     = psel & penable & pwrite & pready;

	// Write the board size register on an access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_size_q <= BOARD_SIZE_RST;
		end else if (wr_en && (reg_index == REG_BOARD_SIZE)) begin
			board_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// Return the register value on reads
	always_comb begin
		prdata = '0;
		case (reg_index)
			REG_BOARD_SIZE: prdata = {{(APB_DW-SIZE_W){1'b0}}, board_size_q};
			default:        prdata = '0;
		endcase
	end

	assign board_size = board_size_q;

endmodule

// ===== hw/rtl/nqse_attack_check.sv =====
// Attack check unit: tests one candidate square against all placed columns.
// Compares row and both diagonals per column in parallel; depends on nqse_pkg.
module nqse_attack_check
	import nqse_pkg::*;
#(
	parameter int MAX_N = MAX_N_DEF
) (
	input  cand_t            cand,
	input  logic [ROW_W-1:0] rows [MAX_N],
	output logic             free
);

	logic [MAX_N-1:0] hit;

	// Flag a conflict with each column left of the candidate
	always_comb begin
		for (int c = 0; c < MAX_N; c++) begin
			logic [COL_W-1:0] q;
			logic [COL_W-1:0] dr;
			logic [COL_W-1:0] dc;
			q  = {{(COL_W-ROW_W){1'b0}}, rows[c]};
			dr = (q > cand.row) ? (q - cand.row) : (cand.row - q);
			dc = cand.col - COL_W'(c);
			hit[c] = (COL_W'(c) < cand.col) && ((q == cand.row) || (dr == dc));
		end
	end

	assign free = ~|hit;

endmodule

// ===== test/tb_n_queens_solution_enumerator_unit.sv =====
`timescale 1ns / 100ps
// Testbench for n_queens_solution_enumerator_unit: directed table, then random request stream.
// Predicts each solution bitmap with its own backtracking search; needs nqse_pkg and the RTL.
module tb_n_queens_solution_enumerator_unit;
	import nqse_pkg::*;

	localparam int EDGE_MAX = MAX_N_DEF;
	localparam int STALL_LIMIT = 200000;
	localparam int PHASE_ITEMS = 300;
	localparam int PRINT_LIMIT = 50;

	typedef enum logic {ROW_REQ, ROW_SIZE} row_kind_t;

	// One line of the directed table: a request or a board size write
	typedef struct packed {
		row_kind_t   kind;
		logic [3:0]  value;
		bit          typed;
		logic        found;
		logic [63:0] board;
	} stim_row_t;

	typedef struct packed {
		logic        found;
		logic [63:0] board;
	} board_result_t;

	localparam int DIRECTED_ROWS = 29;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_REQ,  4'd0,  1'b0, 1'b0, 64'h0},     // no search yet: acts as a restart
		'{ROW_REQ,  4'd0,  1'b0, 1'b0, 64'h0},
		'{ROW_SIZE, 4'd4,  1'b0, 1'b0, 64'h0},     // shrink in the middle of a search
		'{ROW_REQ,  4'd0,  1'b0, 1'b0, 64'h0},
		'{ROW_REQ,  4'd1,  1'b1, 1'b1, 64'h2814},
		'{ROW_REQ,  4'd0,  1'b1, 1'b1, 64'h4182},
		'{ROW_REQ,  4'd0,  1'b1, 1'b0, 64'h0},
		'{ROW_REQ,  4'd0,  1'b1, 1'b0, 64'h0},     // stays exhausted
		'{ROW_SIZE, 4'd1,  1'b0, 1'b0, 64'h0},
		'{ROW_REQ,  4'd1,  1'b1, 1'b1, 64'h1},
		'{ROW_REQ,  4'd0,  1'b1, 1'b0, 64'h0},
		'{ROW_SIZE, 4'd0,  1'b0, 1'b0, 64'h0},     // empty board is the one solution
		'{ROW_REQ,  4'd1,  1'b1, 1'b1, 64'h0},
		'{ROW_REQ,  4'd0,  1'b1, 1'b0, 64'h0},
		'{ROW_SIZE, 4'd2,  1'b0, 1'b0, 64'h0},
		'{ROW_REQ,  4'd1,  1'b1, 1'b0, 64'h0},
		'{ROW_SIZE, 4'd3,  1'b0, 1'b0, 64'h0},
		'{ROW_REQ,  4'd1,  1'b1, 1'b0, 64'h0},
		'{ROW_SIZE, 4'd15, 1'b0, 1'b0, 64'h0},     // saturates to the largest board
		'{ROW_REQ,  4'd1,  1'b0, 1'b0, 64'h0},
		'{ROW_REQ,  4'd0,  1'b0, 1'b0, 64'h0},
		'{ROW_SIZE, 4'd9,  1'b0, 1'b0, 64'h0},
		'{ROW_REQ,  4'd0,  1'b0, 1'b0, 64'h0},
		'{ROW_SIZE, 4'd5,  1'b0, 1'b0, 64'h0},     // stored rows beyond the new edge
		'{ROW_REQ,  4'd0,  1'b0, 1'b0, 64'h0},
		'{ROW_REQ,  4'd1,  1'b0, 1'b0, 64'h0},
		'{ROW_SIZE, 4'd8,  1'b0, 1'b0, 64'h0},     // grow in the middle of a search
		'{ROW_REQ,  4'd0,  1'b0, 1'b0, 64'h0},
		'{ROW_REQ,  4'd0,  1'b0, 1'b0, 64'h0}
	};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;       // from bit 0: restart, zero fill
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [BITS_W-1:0] m_tdata;            // from bit 0: board_bits
	logic              m_tuser;            // from bit 0: found
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Table expectation traveling with the request transaction
	bit          req_typed = 1'b0;
	logic        req_found = 1'b0;
	logic [63:0] req_board = '0;

	int sender_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int result_count = 0;
	int stall_cycles = 0;

	// Predicted search state
	logic [ROW_W-1:0]  queen_rows [EDGE_MAX] = '{default: '0};
	logic [COL_W-1:0]  cols_placed = '0;
	bit                search_live = 1'b0;
	bit                search_done = 1'b0;
	logic [SIZE_W-1:0] board_edge_reg = BOARD_SIZE_RST;

	board_result_t expected_boards [$];

	n_queens_solution_enumerator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s", result_count, msg);
	endtask

	// Append one expected result at the tail of the queue
	task automatic enqueue_expected(input board_result_t item);
		expected_boards.insert(expected_boards.size(), item);
	endtask

	// True if no placed column left of col attacks (row, col)
	function automatic bit row_clear(input int row, input int col);
		int q;
		for (int c = 0; c < col && c < EDGE_MAX; c++) begin
			q = int'(queen_rows[c]);
			if (q == row || (q > row ? q - row : row - q) == col - c)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advance the search by one request and return the next solution
	function automatic void next_placement(input logic restart, output logic hit,
			output logic [63:0] board);
		int n, col, next_row, r, q;
		bit searching, placed;
		n = (int'(board_edge_reg) > EDGE_MAX) ? EDGE_MAX : int'(board_edge_reg);
		searching = 1'b1;
		col = 0;
		next_row = 0;
		board = '0;
		if (restart || !search_live) begin
			foreach (queen_rows[i]) queen_rows[i] = '0;
			search_done = 1'b0;
			search_live = 1'b1;
		end else if (search_done) begin
			searching = 1'b0;
		end else begin
			col = (int'(cols_placed) > n) ? n : int'(cols_placed);
			if (col == 0) begin
				search_done = 1'b1;
				searching = 1'b0;
			end else begin
				col--;
				next_row = int'(queen_rows[col]) + 1;
			end
		end
		// Depth-first: place the lowest free row, else backtrack one column
		while (searching && col < n) begin
			placed = 1'b0;
			r = next_row;
			while (!placed && r < n) begin
				if (row_clear(r, col))
					placed = 1'b1;
				else
					r++;
			end
			if (placed) begin
				queen_rows[col] = ROW_W'(r);
				col++;
				next_row = 0;
			end else if (col == 0) begin
				search_done = 1'b1;
				searching = 1'b0;
			end else begin
				col--;
				next_row = int'(queen_rows[col]) + 1;
			end
		end
		if (searching) begin
			cols_placed = COL_W'(n);
			for (int c = 0; c < n; c++) begin
				q = int'(queen_rows[c]);
				if (q < n)
					board[q * n + c] = 1'b1;
			end
			hit = 1'b1;
		end else begin
			cols_placed = '0;
			hit = 1'b0;
		end
	endfunction

	// Random backpressure on the result side
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Track register writes, predict on each request, check each result
	always @(posedge clk) begin
		logic hit;
		logic [63:0] board;
		board_result_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == {REG_BOARD_SIZE, 2'b00})
				board_edge_reg = pwdata[SIZE_W-1:0];
			if (s_tvalid && s_tready) begin
				next_placement(s_tdata[0], hit, board);
				if (req_typed)
					enqueue_expected('{req_found, req_board});
				else
					enqueue_expected('{hit, board});
			end
			if (m_tvalid && m_tready) begin
				result_count++;
				if (expected_boards.size() == 0) begin
					report_mismatch($sformatf("unrequested result found %0d board %h",
						m_tuser, m_tdata));
				end else begin
					want = expected_boards.pop_front();
					if (m_tuser !== want.found)
						report_mismatch($sformatf("found %0d, expected %0d",
							m_tuser, want.found));
					if (m_tdata !== want.board)
						report_mismatch($sformatf("board %h, expected %h",
							m_tdata, want.board));
				end
			end
			// Watchdog on cycles without any transaction
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Offer one request; valid stays high after the transaction until the next call
	task automatic send_request(input logic restart, input bit typed, input logic found,
			input logic [63:0] board);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, restart};
		req_typed <= typed;
		req_found <= found;
		req_board <= board;
		do @(posedge clk); while (!s_tready);
	endtask

	// Hold requests until every result is back, then let the block settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (expected_boards.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Setup and access cycle; upper data bits carry noise
	task automatic write_board_size(input logic [SIZE_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_BOARD_SIZE, 2'b00};
		pwdata <= {(APB_DW - SIZE_W)'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly small boards, some full size, some zero and oversize
	function automatic logic [SIZE_W-1:0] pick_board_size();
		int w;
		w = $urandom_range(99);
		if (w < 55)
			return SIZE_W'($urandom_range(6, 1));
		else if (w < 70)
			return SIZE_W'(7);
		else if (w < 80)
			return SIZE_W'(8);
		else if (w < 86)
			return '0;
		return SIZE_W'($urandom_range(15, 9));
	endfunction

	// Segments of resumed requests at one board size, occasional restarts and pauses
	task automatic run_phase(input int send_pct, input int recv_pct);
		int sent;
		int seg_len;
		sender_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			drain_results();
			write_board_size(pick_board_size());
			seg_len = $urandom_range(25, 3);
			for (int k = 0; k < seg_len; k++) begin
				if ($urandom_range(29) == 0)
					drain_results();
				send_request($urandom_range(k == 0 ? 1 : 11) == 0, 1'b0, 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_SIZE) begin
				drain_results();
				write_board_size(DIRECTED[i].value);
			end else begin
				send_request(DIRECTED[i].value[0], DIRECTED[i].typed,
					DIRECTED[i].found, DIRECTED[i].board);
			end
		end

		run_phase(17, 87);
		run_phase(87, 17);
		run_phase(0, 0);

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_boards.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
